// ===== rtl/core/sscp_pkg.sv =====
package sscp_pkg;

	localparam int COORD_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int QUO_W     = 34;
	localparam int QS_W      = QUO_W + 1;
	localparam int DIV_STEPS = QUO_W;
	localparam int DIV_LAT   = DIV_STEPS + 3;
	localparam int LANE_LAT  = DIV_LAT + 5;
	localparam int CROSS_LAT = DIV_LAT + 4;
	localparam int ROOT_W    = 35;
	localparam int RREM_W    = ROOT_W + 2;
	localparam int SQRT_LAT  = ROOT_W + 1;
	localparam int DIST_W    = 33;
	localparam int STATUS_W  = 2;

	localparam logic [STATUS_W-1:0] ST_SEPARATE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CROSS    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DEGEN    = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [QS_W-1:0]    quot_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		logic [SUM_W-1:0] dist2;
		point_t           near;
		point_t           probe;
	} lane_out_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		point_t              pt;
	} cross_out_t;

	function automatic diff_t sub_c(input coord_t a, input coord_t b);
		return DIFF_W'(a) - DIFF_W'(b);
	endfunction

	function automatic prod_t smul(input diff_t a, input diff_t b);
		return PROD_W'(a) * PROD_W'(b);
	endfunction

	// The offset always lands inside the segment, so the low bits are exact.
	function automatic coord_t offset(input coord_t base, input quot_t q);
		return COORD_W'(QS_W'(base) + q);
	endfunction

endpackage

// ===== rtl/core/sscp_div.sv =====
module sscp_div import sscp_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [SUM_W-1:0] num,
	input  logic [SUM_W-1:0] den,
	input  diff_t            mul,
	input  logic             neg,
	output quot_t            quo
);

	localparam int PP_W = SUM_W + DIFF_W;

	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [QUO_W-1:0] low;
		logic [QUO_W-1:0] q;
		logic [SUM_W-1:0] den;
		logic             neg;
	} step_t;

	function automatic step_t div_step(input step_t cur);
		logic [SUM_W:0] trial;
		step_t          nxt;
		nxt = cur;
		trial = {cur.rem, cur.low[QUO_W-1]};
		nxt.low = {cur.low[QUO_W-2:0], 1'b0};
		if (trial >= {1'b0, cur.den}) begin
			nxt.rem = SUM_W'(trial - {1'b0, cur.den});
			nxt.q = {cur.q[QUO_W-2:0], 1'b1};
		end else begin
			nxt.rem = trial[SUM_W-1:0];
			nxt.q = {cur.q[QUO_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	logic [DIFF_W-1:0] mag;
	logic [SUM_W-1:0]  pl_s1, ph_s1, den_s1;
	logic              neg_s1;
	logic [PP_W-1:0]   prod;
	step_t             step_s [0:DIV_STEPS];
	step_t             last;
	logic              up;
	quot_t             qmag;

	assign mag = mul[DIFF_W-1] ? -mul : mul;

	// The wide product is split in two partial products and summed a stage later.
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= SUM_W'(num[QUO_W-1:0]) * SUM_W'(mag);
			ph_s1 <= SUM_W'(num[SUM_W-1:QUO_W]) * SUM_W'(mag);
			den_s1 <= den;
			neg_s1 <= neg;
		end
	end

	assign prod = PP_W'(pl_s1) + (PP_W'(ph_s1) << QUO_W);

	always_ff @(posedge clk) begin
		if (en) begin
			step_s[0].rem <= SUM_W'(prod[PP_W-1:QUO_W]);
			step_s[0].low <= prod[QUO_W-1:0];
			step_s[0].q <= '0;
			step_s[0].den <= den_s1;
			step_s[0].neg <= neg_s1;
			for (int k = 0; k < DIV_STEPS; k++) begin
				step_s[k+1] <= div_step(step_s[k]);
			end
		end
	end

	// Round to nearest, ties away from zero, then apply the sign.
	assign last = step_s[DIV_STEPS];
	assign up = {last.rem, 1'b0} >= {1'b0, last.den};
	assign qmag = QS_W'(last.q) + QS_W'(up);

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= last.neg ? -qmag : qmag;
		end
	end

endmodule

// ===== rtl/core/sscp_lane.sv =====
module sscp_lane import sscp_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  point_t    seg_s,
	input  point_t    seg_e,
	input  point_t    probe,
	output lane_out_t res
);

	typedef struct packed {
		point_t s;
		point_t e;
		point_t p;
	} pts_t;

	typedef struct packed {
		pts_t pts;
		logic at_start;
		logic at_end;
	} pend_t;

	pts_t   pts_in, pts_s1, pts_s2;
	prod_t  llx_s1, lly_s1, dpx_s1, dpy_s1;
	diff_t  dx_s1, dy_s1, dx_s2, dy_s2;
	sum_t   l2_s2, dot_s2;
	pend_t  pend_s [0:DIV_LAT-1];
	pend_t  pend_last;
	quot_t  qx, qy;
	point_t near_s4;
	coord_t px_s4, py_s4;
	prod_t  fxx_s5, fyy_s5;
	point_t near_s5, probe_s5;
	diff_t  dx, dy, wx, wy;

	assign pts_in = '{s: seg_s, e: seg_e, p: probe};
	assign dx = sub_c(seg_e.x, seg_s.x);
	assign dy = sub_c(seg_e.y, seg_s.y);
	assign wx = sub_c(probe.x, seg_s.x);
	assign wy = sub_c(probe.y, seg_s.y);

	always_ff @(posedge clk) begin
		if (en) begin
			llx_s1 <= smul(dx, dx);
			lly_s1 <= smul(dy, dy);
			dpx_s1 <= smul(wx, dx);
			dpy_s1 <= smul(wy, dy);
			dx_s1 <= dx;
			dy_s1 <= dy;
			pts_s1 <= pts_in;

			l2_s2 <= SUM_W'(llx_s1) + SUM_W'(lly_s1);
			dot_s2 <= SUM_W'(dpx_s1) + SUM_W'(dpy_s1);
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			pts_s2 <= pts_s1;
		end
	end

	sscp_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (dot_s2),
		.den (l2_s2),
		.mul (dx_s2),
		.neg (dx_s2[DIFF_W-1]),
		.quo (qx)
	);

	sscp_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (dot_s2),
		.den (l2_s2),
		.mul (dy_s2),
		.neg (dy_s2[DIFF_W-1]),
		.quo (qy)
	);

	// A zero-length segment or a non-positive dot product clamps to the start point.
	always_ff @(posedge clk) begin
		if (en) begin
			pend_s[0].pts <= pts_s2;
			pend_s[0].at_start <= (l2_s2 == '0) || (dot_s2 <= 0);
			pend_s[0].at_end <= dot_s2 >= l2_s2;
			for (int k = 1; k < DIV_LAT; k++) begin
				pend_s[k] <= pend_s[k-1];
			end
		end
	end

	assign pend_last = pend_s[DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (pend_last.at_start) begin
				near_s4 <= pend_last.pts.s;
			end else if (pend_last.at_end) begin
				near_s4 <= pend_last.pts.e;
			end else begin
				near_s4.x <= offset(pend_last.pts.s.x, qx);
				near_s4.y <= offset(pend_last.pts.s.y, qy);
			end
			px_s4 <= pend_last.pts.p.x;
			py_s4 <= pend_last.pts.p.y;

			fxx_s5 <= smul(sub_c(px_s4, near_s4.x), sub_c(px_s4, near_s4.x));
			fyy_s5 <= smul(sub_c(py_s4, near_s4.y), sub_c(py_s4, near_s4.y));
			near_s5 <= near_s4;
			probe_s5 <= '{x: px_s4, y: py_s4};

			res.dist2 <= SUM_W'(fxx_s5) + SUM_W'(fyy_s5);
			res.near <= near_s5;
			res.probe <= probe_s5;
		end
	end

endmodule

// ===== rtl/core/sscp_cross.sv =====
module sscp_cross import sscp_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  point_t     a_s,
	input  point_t     a_e,
	input  point_t     b_s,
	input  point_t     b_e,
	output cross_out_t res
);

	typedef struct packed {
		point_t org;
		logic   crossing;
		logic   degen;
	} pend_t;

	function automatic logic same_side(input sum_t p, input sum_t q);
		return (p != '0) && (q != '0) && (p[SUM_W-1] == q[SUM_W-1]);
	endfunction

	diff_t  ux, uy, vx, vy;
	prod_t  c1a_s1, c1b_s1, c2a_s1, c2b_s1, c3a_s1, c3b_s1, c4a_s1, c4b_s1;
	prod_t  na_s1, nb_s1, da_s1, db_s1;
	diff_t  ux_s1, uy_s1, ux_s2, uy_s2, ux_s3, uy_s3;
	point_t org_s1, org_s2;
	logic   zero_s1, zero_s2;
	sum_t   c1_s2, c2_s2, c3_s2, c4_s2, numer_s2, denom_s2;
	logic   crossing;
	logic   [SUM_W-1:0] nmag_s3, dmag_s3;
	logic   negx_s3, negy_s3;
	pend_t  pend_s [0:DIV_LAT];
	pend_t  pend_last;
	quot_t  qx, qy;

	assign ux = sub_c(a_e.x, a_s.x);
	assign uy = sub_c(a_e.y, a_s.y);
	assign vx = sub_c(b_e.x, b_s.x);
	assign vy = sub_c(b_e.y, b_s.y);

	always_ff @(posedge clk) begin
		if (en) begin
			c1a_s1 <= smul(ux, sub_c(b_s.y, a_e.y));
			c1b_s1 <= smul(uy, sub_c(b_s.x, a_e.x));
			c2a_s1 <= smul(ux, sub_c(b_e.y, a_e.y));
			c2b_s1 <= smul(uy, sub_c(b_e.x, a_e.x));
			c3a_s1 <= smul(vx, sub_c(a_s.y, b_e.y));
			c3b_s1 <= smul(vy, sub_c(a_s.x, b_e.x));
			c4a_s1 <= smul(vx, sub_c(a_e.y, b_e.y));
			c4b_s1 <= smul(vy, sub_c(a_e.x, b_e.x));
			na_s1 <= smul(vx, sub_c(b_s.y, a_s.y));
			nb_s1 <= smul(vy, sub_c(a_s.x, b_s.x));
			da_s1 <= smul(uy, vx);
			db_s1 <= smul(ux, vy);
			ux_s1 <= ux;
			uy_s1 <= uy;
			org_s1 <= a_s;
			zero_s1 <= (a_s == a_e) || (b_s == b_e);

			c1_s2 <= SUM_W'(c1a_s1) - SUM_W'(c1b_s1);
			c2_s2 <= SUM_W'(c2a_s1) - SUM_W'(c2b_s1);
			c3_s2 <= SUM_W'(c3a_s1) - SUM_W'(c3b_s1);
			c4_s2 <= SUM_W'(c4a_s1) - SUM_W'(c4b_s1);
			numer_s2 <= SUM_W'(na_s1) + SUM_W'(nb_s1);
			denom_s2 <= SUM_W'(da_s1) - SUM_W'(db_s1);
			ux_s2 <= ux_s1;
			uy_s2 <= uy_s1;
			org_s2 <= org_s1;
			zero_s2 <= zero_s1;
		end
	end

	// Touching counts as crossing: only strictly same-side endpoints separate.
	assign crossing = !same_side(c1_s2, c2_s2) && !same_side(c3_s2, c4_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s3 <= numer_s2[SUM_W-1] ? -numer_s2 : numer_s2;
			dmag_s3 <= denom_s2[SUM_W-1] ? -denom_s2 : denom_s2;
			negx_s3 <= numer_s2[SUM_W-1] ^ denom_s2[SUM_W-1] ^ ux_s2[DIFF_W-1];
			negy_s3 <= numer_s2[SUM_W-1] ^ denom_s2[SUM_W-1] ^ uy_s2[DIFF_W-1];
			ux_s3 <= ux_s2;
			uy_s3 <= uy_s2;

			pend_s[0].org <= org_s2;
			pend_s[0].crossing <= crossing;
			pend_s[0].degen <= zero_s2 || (denom_s2 == '0);
			for (int k = 1; k <= DIV_LAT; k++) begin
				pend_s[k] <= pend_s[k-1];
			end
		end
	end

	sscp_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (nmag_s3),
		.den (dmag_s3),
		.mul (ux_s3),
		.neg (negx_s3),
		.quo (qx)
	);

	sscp_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (nmag_s3),
		.den (dmag_s3),
		.mul (uy_s3),
		.neg (negy_s3),
		.quo (qy)
	);

	assign pend_last = pend_s[DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			if (!pend_last.crossing) begin
				res.status <= ST_SEPARATE;
				res.pt <= '0;
			end else if (pend_last.degen) begin
				res.status <= ST_DEGEN;
				res.pt <= '0;
			end else begin
				res.status <= ST_CROSS;
				res.pt.x <= offset(pend_last.org.x, qx);
				res.pt.y <= offset(pend_last.org.y, qy);
			end
		end
	end

endmodule

// ===== rtl/core/sscp_sqrt.sv =====
module sscp_sqrt import sscp_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [SUM_W-1:0]  sq,
	output logic [DIST_W-1:0] root
);

	localparam int RAD_W = 2 * ROOT_W;
	localparam int TW    = RREM_W + 2;

	typedef struct packed {
		logic [RREM_W-1:0] rem;
		logic [ROOT_W-1:0] rt;
		logic [RAD_W-1:0]  bits;
	} sq_step_t;

	function automatic sq_step_t sq_step(input sq_step_t cur);
		logic [TW-1:0] rem4;
		logic [TW-1:0] trial;
		sq_step_t      nxt;
		nxt = cur;
		rem4 = {cur.rem, cur.bits[RAD_W-1 -: 2]};
		trial = TW'({cur.rt, 2'b01});
		nxt.bits = cur.bits << 2;
		if (rem4 >= trial) begin
			nxt.rem = RREM_W'(rem4 - trial);
			nxt.rt = {cur.rt[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem = RREM_W'(rem4);
			nxt.rt = {cur.rt[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	sq_step_t seed;
	sq_step_t step_s [0:ROOT_W-1];
	sq_step_t last;
	logic     up;

	assign seed = '{rem: '0, rt: '0, bits: RAD_W'(sq)};

	always_ff @(posedge clk) begin
		if (en) begin
			step_s[0] <= sq_step(seed);
			for (int k = 1; k < ROOT_W; k++) begin
				step_s[k] <= sq_step(step_s[k-1]);
			end
		end
	end

	// The remainder is sq - rt*rt; above rt the value is nearer rt + 1.
	assign last = step_s[ROOT_W-1];
	assign up = last.rem > RREM_W'(last.rt);

	always_ff @(posedge clk) begin
		if (en) begin
			root <= DIST_W'({1'b0, last.rt} + (ROOT_W+1)'(up));
		end
	end

endmodule

// ===== rtl/core/segment_segment_closest_points.sv =====
// Channel  Handshake                  Payload
// pair     pair_valid / pair_stall    a_start_x/y, a_end_x/y, b_start_x/y, b_end_x/y
// result   result_valid / result_stall status, distance, near_a_x/y, near_b_x/y
//
// One segment pair is taken every cycle while pair_stall is low; each result leaves the
// pipeline with result_valid and transfers out in a cycle in which result_stall is low.
// The pipeline depth is set by the 34-step pipelined dividers in each lane and the 35-step
// pipelined square root after the merge.
// Reset clears only the valid bits of the pipeline.
// A stalled result freezes the whole pipeline, and pair_stall follows it in the same cycle.
module segment_segment_closest_points import sscp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pair_valid,
	output logic                pair_stall,
	input  logic signed [31:0]  a_start_x,
	input  logic signed [31:0]  a_start_y,
	input  logic signed [31:0]  a_end_x,
	input  logic signed [31:0]  a_end_y,
	input  logic signed [31:0]  b_start_x,
	input  logic signed [31:0]  b_start_y,
	input  logic signed [31:0]  b_end_x,
	input  logic signed [31:0]  b_end_y,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [1:0]          status,
	output logic [32:0]         distance,
	output logic signed [31:0]  near_a_x,
	output logic signed [31:0]  near_a_y,
	output logic signed [31:0]  near_b_x,
	output logic signed [31:0]  near_b_y
);

	localparam int PIPE_DEPTH = LANE_LAT + SQRT_LAT + 4;
	localparam int CROSS_GAP  = LANE_LAT + 1 - CROSS_LAT;

	typedef struct packed {
		logic [SUM_W-1:0] dist2;
		point_t           a;
		point_t           b;
	} cand_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		point_t              a;
		point_t              b;
	} res_t;

	logic                  en;
	logic [PIPE_DEPTH-1:0] valid_q;
	point_t                as_s1, ae_s1, bs_s1, be_s1;
	lane_out_t             lane_res [0:3];
	cand_t                 cand [0:3];
	cross_out_t            cross_res;
	cross_out_t            xdly_s [0:CROSS_GAP-1];
	cand_t                 m01_s1, m23_s1, best_s2;
	res_t                  res_s2;
	res_t                  rdly_s [0:SQRT_LAT-1];
	res_t                  fin;
	logic [DIST_W-1:0]     root;
	logic [STATUS_W-1:0]   status_q;
	logic [DIST_W-1:0]     distance_q;
	point_t                near_a_q, near_b_q;

	assign result_valid = valid_q[PIPE_DEPTH-1];
	assign en = !(result_valid && result_stall);
	assign pair_stall = result_valid && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[PIPE_DEPTH-2:0], pair_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			as_s1 <= '{x: a_start_x, y: a_start_y};
			ae_s1 <= '{x: a_end_x, y: a_end_y};
			bs_s1 <= '{x: b_start_x, y: b_start_y};
			be_s1 <= '{x: b_end_x, y: b_end_y};
		end
	end

	// Candidates in tie-break order: A ends onto B, then B ends onto A.
	sscp_lane u_lane0 (.clk(clk), .en(en), .seg_s(bs_s1), .seg_e(be_s1), .probe(as_s1),
		.res(lane_res[0]));
	sscp_lane u_lane1 (.clk(clk), .en(en), .seg_s(bs_s1), .seg_e(be_s1), .probe(ae_s1),
		.res(lane_res[1]));
	sscp_lane u_lane2 (.clk(clk), .en(en), .seg_s(as_s1), .seg_e(ae_s1), .probe(bs_s1),
		.res(lane_res[2]));
	sscp_lane u_lane3 (.clk(clk), .en(en), .seg_s(as_s1), .seg_e(ae_s1), .probe(be_s1),
		.res(lane_res[3]));

	sscp_cross u_cross (
		.clk (clk),
		.en  (en),
		.a_s (as_s1),
		.a_e (ae_s1),
		.b_s (bs_s1),
		.b_e (be_s1),
		.res (cross_res)
	);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cand[k].dist2 = lane_res[k].dist2;
			if (k < 2) begin
				cand[k].a = lane_res[k].probe;
				cand[k].b = lane_res[k].near;
			end else begin
				cand[k].a = lane_res[k].near;
				cand[k].b = lane_res[k].probe;
			end
		end
	end

	// Comparing with <= keeps the left operand on a tie, so the earliest candidate wins.
	always_ff @(posedge clk) begin
		if (en) begin
			xdly_s[0] <= cross_res;
			for (int k = 1; k < CROSS_GAP; k++) begin
				xdly_s[k] <= xdly_s[k-1];
			end

			m01_s1 <= (cand[0].dist2 <= cand[1].dist2) ? cand[0] : cand[1];
			m23_s1 <= (cand[2].dist2 <= cand[3].dist2) ? cand[2] : cand[3];

			best_s2 <= (m01_s1.dist2 <= m23_s1.dist2) ? m01_s1 : m23_s1;
			if (xdly_s[CROSS_GAP-1].status != ST_SEPARATE) begin
				res_s2.status <= xdly_s[CROSS_GAP-1].status;
				res_s2.a <= xdly_s[CROSS_GAP-1].pt;
				res_s2.b <= xdly_s[CROSS_GAP-1].pt;
			end else begin
				res_s2.status <= ST_SEPARATE;
				res_s2.a <= (m01_s1.dist2 <= m23_s1.dist2) ? m01_s1.a : m23_s1.a;
				res_s2.b <= (m01_s1.dist2 <= m23_s1.dist2) ? m01_s1.b : m23_s1.b;
			end

			rdly_s[0] <= res_s2;
			for (int k = 1; k < SQRT_LAT; k++) begin
				rdly_s[k] <= rdly_s[k-1];
			end
		end
	end

	sscp_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.sq   (best_s2.dist2),
		.root (root)
	);

	assign fin = rdly_s[SQRT_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= fin.status;
			distance_q <= (fin.status == ST_SEPARATE) ? root : '0;
			near_a_q <= fin.a;
			near_b_q <= fin.b;
		end
	end

	assign status = status_q;
	assign distance = distance_q;
	assign near_a_x = near_a_q.x;
	assign near_a_y = near_a_q.y;
	assign near_b_x = near_b_q.x;
	assign near_b_y = near_b_q.y;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import sscp_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [1:0]  status;
		logic [32:0] distance;
		coord_t      ax;
		coord_t      ay;
		coord_t      bx;
		coord_t      by;
	} closest_t;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 120;

	logic        clk;
	logic        arst_n;
	logic        pair_valid;
	logic        pair_stall;
	coord_t      a_start_x, a_start_y, a_end_x, a_end_y;
	coord_t      b_start_x, b_start_y, b_end_x, b_end_y;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  status;
	logic [32:0] distance;
	coord_t      near_a_x, near_a_y, near_b_x, near_b_y;

	closest_t pending_results[$];
	int       errors;
	int       pairs_sent;
	int       results_checked;
	int       crossings_seen;
	int       degenerate_seen;
	int       quiet_cycles;
	bit       idle_on;
	bit       hold_request;

	segment_segment_closest_points dut (
		.clk(clk), .arst_n(arst_n),
		.pair_valid(pair_valid), .pair_stall(pair_stall),
		.a_start_x(a_start_x), .a_start_y(a_start_y),
		.a_end_x(a_end_x), .a_end_y(a_end_y),
		.b_start_x(b_start_x), .b_start_y(b_start_y),
		.b_end_x(b_end_x), .b_end_y(b_end_y),
		.result_valid(result_valid), .result_stall(result_stall),
		.status(status), .distance(distance),
		.near_a_x(near_a_x), .near_a_y(near_a_y),
		.near_b_x(near_b_x), .near_b_y(near_b_y)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic wide_t wmul(input longint a, input longint b);
		return wide_t'(a) * wide_t'(b);
	endfunction

	function automatic int sgn(input wide_t v);
		return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
	endfunction

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// round(num*mul/den), ties away from zero, magnitude clamped to 2^40
	function automatic longint scaled_quot(input wide_t num, input longint mul,
			input wide_t den);
		bit    neg;
		wide_t an, ad, am, prod, q, r;
		neg = (num < 0) != ((mul < 0) != (den < 0));
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		am = (mul < 0) ? -wide_t'(mul) : wide_t'(mul);
		prod = an * am;
		q = prod / ad;
		r = prod % ad;
		if (2 * r >= ad)
			q = q + 1;
		if (q > (wide_t'(1) <<< 40))
			q = wide_t'(1) <<< 40;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic wide_t nearest_on(input longint sx, input longint sy, input longint ex,
			input longint ey, input longint px, input longint py,
			output longint nx, output longint ny);
		longint dx, dy, fx, fy;
		wide_t  len2, dot;
		dx = ex - sx;
		dy = ey - sy;
		len2 = wmul(dx, dx) + wmul(dy, dy);
		dot = wmul(px - sx, dx) + wmul(py - sy, dy);
		if (len2 == 0 || dot <= 0) begin
			nx = sx;
			ny = sy;
		end else if (dot >= len2) begin
			nx = ex;
			ny = ey;
		end else begin
			nx = sx + scaled_quot(dot, dx, len2);
			ny = sy + scaled_quot(dot, dy, len2);
		end
		fx = px - nx;
		fy = py - ny;
		return wmul(fx, fx) + wmul(fy, fy);
	endfunction

	function automatic longint rounded_root(input wide_t s);
		wide_t root, c;
		root = 0;
		for (int b = 34; b >= 0; b--) begin
			c = root | (wide_t'(1) <<< b);
			if (c * c <= s)
				root = c;
		end
		if (s - root * root > root)
			root = root + 1;
		return longint'(root);
	endfunction

	function automatic closest_t predict_closest(input coord_t p[8]);
		longint   x1, y1, x2, y2, x3, y3, x4, y4, ux, uy, vx, vy;
		longint   nx[4], ny[4];
		wide_t    numer, denom, d2[4];
		bit       crossing;
		int       best;
		closest_t r;
		x1 = p[0]; y1 = p[1]; x2 = p[2]; y2 = p[3];
		x3 = p[4]; y3 = p[5]; x4 = p[6]; y4 = p[7];
		ux = x2 - x1; uy = y2 - y1; vx = x4 - x3; vy = y4 - y3;
		r = '{default: '0};
		crossing = 1'b1;
		if (sgn(wmul(ux, y3 - y2) - wmul(uy, x3 - x2)) *
				sgn(wmul(ux, y4 - y2) - wmul(uy, x4 - x2)) > 0)
			crossing = 1'b0;
		if (crossing && sgn(wmul(vx, y1 - y4) - wmul(vy, x1 - x4)) *
				sgn(wmul(vx, y2 - y4) - wmul(vy, x2 - x4)) > 0)
			crossing = 1'b0;
		if (crossing) begin
			numer = wmul(vx, y3 - y1) + wmul(vy, x1 - x3);
			denom = wmul(uy, vx) - wmul(ux, vy);
			if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0) || denom == 0) begin
				r.status = ST_DEGEN;
			end else begin
				r.status = ST_CROSS;
				r.ax = coord_t'(sat32(x1 + scaled_quot(numer, ux, denom)));
				r.ay = coord_t'(sat32(y1 + scaled_quot(numer, uy, denom)));
				r.bx = r.ax;
				r.by = r.ay;
			end
		end else begin
			d2[0] = nearest_on(x3, y3, x4, y4, x1, y1, nx[0], ny[0]);
			d2[1] = nearest_on(x3, y3, x4, y4, x2, y2, nx[1], ny[1]);
			d2[2] = nearest_on(x1, y1, x2, y2, x3, y3, nx[2], ny[2]);
			d2[3] = nearest_on(x1, y1, x2, y2, x4, y4, nx[3], ny[3]);
			if (d2[0] <= d2[1] && d2[0] <= d2[2] && d2[0] <= d2[3])
				best = 0;
			else if (d2[1] <= d2[2] && d2[1] <= d2[3])
				best = 1;
			else if (d2[2] <= d2[3])
				best = 2;
			else
				best = 3;
			r.status = ST_SEPARATE;
			r.distance = 33'(rounded_root(d2[best]));
			case (best)
				0: begin r.ax = p[0]; r.ay = p[1];
					r.bx = coord_t'(sat32(nx[0])); r.by = coord_t'(sat32(ny[0])); end
				1: begin r.ax = p[2]; r.ay = p[3];
					r.bx = coord_t'(sat32(nx[1])); r.by = coord_t'(sat32(ny[1])); end
				2: begin r.bx = p[4]; r.by = p[5];
					r.ax = coord_t'(sat32(nx[2])); r.ay = coord_t'(sat32(ny[2])); end
				default: begin r.bx = p[6]; r.by = p[7];
					r.ax = coord_t'(sat32(nx[3])); r.ay = coord_t'(sat32(ny[3])); end
			endcase
		end
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_pair(input coord_t p[8]);
		closest_t exp_r;
		while (idle_on && $urandom_range(99) < 26) begin
			pair_valid <= 1'b0;
			@(negedge clk);
		end
		pair_valid <= 1'b1;
		a_start_x <= p[0]; a_start_y <= p[1]; a_end_x <= p[2]; a_end_y <= p[3];
		b_start_x <= p[4]; b_start_y <= p[5]; b_end_x <= p[6]; b_end_y <= p[7];
		do
			@(posedge clk);
		while (pair_stall);
		exp_r = predict_closest(p);
		pending_results.insert(pending_results.size(), exp_r);
		pairs_sent++;
		if (exp_r.status == ST_CROSS)
			crossings_seen++;
		if (exp_r.status == ST_DEGEN)
			degenerate_seen++;
		@(negedge clk);
	endtask

	task automatic send_coords(input coord_t x1, y1, x2, y2, x3, y3, x4, y4);
		coord_t p[8];
		p = '{x1, y1, x2, y2, x3, y3, x4, y4};
		send_pair(p);
	endtask

	function automatic coord_t near_coord(input coord_t base, input int unsigned spread);
		return coord_t'(longint'(base) + longint'($urandom_range(2 * spread)) - longint'(spread));
	endfunction

	task automatic report(input string field, input longint exp_v, input longint act_v);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		closest_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result transfer with nothing expected", $time);
			end else begin
				exp_r = pending_results.pop_front();
				results_checked++;
				if (status !== exp_r.status)
					report("status", exp_r.status, status);
				if (distance !== exp_r.distance)
					report("distance", exp_r.distance, distance);
				if (near_a_x !== exp_r.ax)
					report("near_a_x", exp_r.ax, near_a_x);
				if (near_a_y !== exp_r.ay)
					report("near_a_y", exp_r.ay, near_a_y);
				if (near_b_x !== exp_r.bx)
					report("near_b_x", exp_r.bx, near_b_x);
				if (near_b_y !== exp_r.by)
					report("near_b_y", exp_r.by, near_b_y);
			end
		end
	end

	// Receiver: random stalls, or one long hold-off when asked for.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				result_stall <= 1'b0;
			end else begin
				result_stall <= idle_on && ($urandom_range(99) < 26);
			end
		end
	end

	always @(posedge clk) begin
		if ((pair_valid && !pair_stall) || (result_valid && !result_stall) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("[segment_segment_closest_points] ERROR");
			$finish;
		end
	end

	task automatic test_directed();
		coord_t one, mx, mn;
		one = 32'sh0001_0000;
		mx = 32'sh7fff_ffff;
		mn = -32'sh8000_0000;
		// Plain X crossing and a touch at an endpoint.
		send_coords(-one, -one, one, one, -one, one, one, -one);
		send_coords(0, 0, 2 * one, 0, one, 0, one, 3 * one);
		// Collinear overlap and parallel separate segments.
		send_coords(0, 0, 4 * one, 0, one, 0, 6 * one, 0);
		send_coords(0, 0, 4 * one, 0, one, one, 6 * one, one);
		// Zero-length segments: on the other segment, apart, and both at one point.
		send_coords(one, 0, one, 0, 0, 0, 2 * one, 0);
		send_coords(one, one, one, one, 0, 0, 2 * one, 0);
		send_coords(3, 5, 3, 5, 3, 5, 3, 5);
		send_coords(0, 0, 0, 0, 7 * one, -3 * one, 7 * one, -3 * one);
		// Equal distances on all four candidates.
		send_coords(0, 0, 0, 10 * one, 5 * one, 0, 5 * one, 10 * one);
		// Interior projections with odd rounding.
		send_coords(0, 0, 3, 7, 5, 1, 9, 9);
		send_coords(1, 0, 4, 3, 0, 2, -5, 9);
		// Extremes of the coordinate range.
		send_coords(mn, mn, mx, mx, mn, mx, mx, mn);
		send_coords(mn, mn, mn, mn, mx, mx, mx, mx);
		send_coords(mx, mn, mx, mn, mn, mx, mn, mx);
		send_coords(mn, 0, mx, 0, 0, mn, 0, mx);
		send_coords(mx, mx, mx, mn, mn, mx, mn, mn);
		send_coords(mn, mn, mx, mn + 1, mn + 1, mn, mx, mn + 3);
		send_coords(-1, -1, 1, 1, mx, mn, mn, mx);
	endtask

	task automatic random_pair();
		coord_t p[8], cx, cy;
		int unsigned spread;
		int kind;
		kind = $urandom_range(99);
		spread = ($urandom_range(3) == 0) ? 32'h7fff_ffff : ($urandom_range(1) ? 4096 : 200);
		cx = $urandom;
		cy = $urandom;
		if (spread < 32'h7fff_ffff) begin
			cx = coord_t'(cx >>> $urandom_range(31));
			cy = coord_t'(cy >>> $urandom_range(31));
		end
		for (int i = 0; i < 8; i++)
			p[i] = (spread == 32'h7fff_ffff) ? coord_t'($urandom) :
				near_coord((i % 2) ? cy : cx, spread);
		if (kind < 20) begin
			// Segments through a common point.
			p[0] = near_coord(cx, 1000); p[1] = near_coord(cy, 1000);
			p[2] = coord_t'(2 * longint'(cx) - p[0]);
			p[3] = coord_t'(2 * longint'(cy) - p[1]);
			p[4] = near_coord(cx, 1000); p[5] = near_coord(cy, 1000);
			p[6] = coord_t'(2 * longint'(cx) - p[4]);
			p[7] = coord_t'(2 * longint'(cy) - p[5]);
		end else if (kind < 28) begin
			// Collinear along an axis.
			p[1] = cy; p[3] = cy; p[5] = cy; p[7] = cy;
		end else if (kind < 36) begin
			p[2] = p[0]; p[3] = p[1];
		end else if (kind < 42) begin
			p[6] = p[4]; p[7] = p[5];
		end else if (kind < 50) begin
			// Shared endpoint.
			p[4] = p[$urandom_range(1) * 2]; p[5] = p[4] == p[0] ? p[1] : p[3];
		end
		send_pair(p);
	endtask

	task automatic test_random(input int count);
		repeat (count) random_pair();
	endtask

	task automatic test_no_idle(input int count);
		idle_on = 1'b0;
		repeat (count) random_pair();
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure(input int count);
		hold_request = 1'b1;
		repeat (count) random_pair();
	endtask

	initial begin
		errors = 0;
		pairs_sent = 0;
		results_checked = 0;
		crossings_seen = 0;
		degenerate_seen = 0;
		quiet_cycles = 0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		arst_n = 1'b0;
		pair_valid = 1'b0;
		a_start_x = '0; a_start_y = '0; a_end_x = '0; a_end_y = '0;
		b_start_x = '0; b_start_y = '0; b_end_x = '0; b_end_y = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(700);
		test_no_idle(400);
		test_backpressure(200);
		test_random(500);
		pair_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d segment pairs and checked %0d results",
			pairs_sent, results_checked);
		$display("(%0d crossings, %0d degenerate).", crossings_seen, degenerate_seen);
		$display("Covered axis extremes, zero-length and collinear cases,");
		$display("random stalls and a long hold-off.");
		if (errors == 0)
			$display("[segment_segment_closest_points] OK");
		else
			$display("[segment_segment_closest_points] ERROR");
		$finish;
	end

endmodule
